// File: rtl/rlep_pkg.sv
// Shared types and constants for the radix literal expression parser.
package rlep_pkg;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } rlep_in_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } rlep_out_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_DIGIT = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_NO_OP     = 3'd3;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd4;
    localparam logic [2:0] ST_TOO_LONG  = 3'd5;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_AND = 3'd2;
    localparam logic [2:0] OP_OR  = 3'd3;
    localparam logic [2:0] OP_MUL = 3'd4;
    localparam logic [2:0] OP_DIV = 3'd5;

    localparam logic [1:0] RX_DEC = 2'd0;
    localparam logic [1:0] RX_HEX = 2'd1;
    localparam logic [1:0] RX_OCT = 2'd2;
    localparam logic [1:0] RX_BIN = 2'd3;

    localparam logic [2:0] PH_FIRST = 3'd0;
    localparam logic [2:0] PH_LIT   = 3'd1;
    localparam logic [2:0] PH_LEFT  = 3'd2;
    localparam logic [2:0] PH_RIGHT = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load;      // take in_word's character into the parse state
        logic fin;       // it is the last: latch the final operands
        logic div_start; // load the divider
        logic div_step;  // one quotient bit
        logic mul_lo;    // first partial product pass
        logic mul_hi;    // second partial product pass
        logic res_load;  // capture result word
    } rlep_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_mul;
        logic need_div;
        logic div_done;
    } rlep_sts_t;

    // digit value, or 31 for a character that is no digit in any radix
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            return 5'(c[2:0]) + 5'd9;
        else return 5'h1F;
    endfunction

    function automatic logic [2:0] op_of(input logic [7:0] c, output logic hit);
        hit = 1'b1;
        case (c)
            8'h2B: return OP_ADD;
            8'h2D: return OP_SUB;
            8'h26: return OP_AND;
            8'h7C: return OP_OR;
            8'h2A: return OP_MUL;
            8'h2F: return OP_DIV;
            default:
            begin
                hit = 1'b0;
                return OP_ADD;
            end
        endcase
    endfunction

endpackage

// File: rtl/rlep_ctrl.sv
// Sequencing controller for the parser: handshakes and arithmetic steps.
module rlep_ctrl
    import rlep_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      in_last,
    output logic      out_valid,
    input  logic      out_ready,
    output rlep_cmd_t cmd,
    input  rlep_sts_t sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_RES  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       take;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign take      = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = take;
                cmd.fin  = take && in_last;
                if (take && in_last)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (sts.need_mul)
                    state_next = S_MUL;
                else if (sts.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                    state_next = S_RES;
            end
            S_MUL:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_RES;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_RES;
            end
            S_RES:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("input taken while evaluating");
    a_res_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid_reg || out_ready))
        else $error("result overwrote a waiting word");
    a_fin_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> state_reg == S_EVAL)
        else $error("last word did not start evaluation");
`endif

endmodule

// File: rtl/rlep_dp.sv
// Parse state, digit accumulation and final arithmetic for the parser.
module rlep_dp
    import rlep_pkg::*;
#(
    parameter int OPERAND_MAX = 40
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  rlep_in_t  in_word,
    input  rlep_cmd_t cmd,
    output rlep_sts_t sts,
    output rlep_out_t out_word
);

    // parse state
    logic        expr_reg;
    logic [2:0]  phase_reg;
    logic [1:0]  radix_reg;
    logic [31:0] acc_reg;
    logic [31:0] left_reg;
    logic [2:0]  opc_reg;
    logic [7:0]  len_reg;
    logic [2:0]  err_reg;
    logic        close_reg;
    logic        lz_reg, pre_reg, bad_reg, long_reg, rop_reg, rest_reg;

    logic        expr_next;
    logic [2:0]  phase_next;
    logic [1:0]  radix_next;
    logic [31:0] acc_next;
    logic [31:0] left_next;
    logic [2:0]  opc_next;
    logic [7:0]  len_next;
    logic [2:0]  err_next;
    logic        close_next;
    logic        lz_next, pre_next, bad_next, long_next, rop_next, rest_next;

    // evaluation operands
    logic [31:0] a_reg, b_reg, res_reg;
    logic [2:0]  st_reg, st_fin;
    logic [31:0] b_fin, a_fin;
    logic        mode_div_reg, mode_mul_reg;
    logic [31:0] rem_reg, quo_reg, ma_reg;
    logic        neg_reg;
    logic [4:0]  dcnt_reg;
    logic [31:0] mlo_reg;
    logic [31:0] mhi;

    logic [7:0]  c;
    logic        is_op;
    logic [2:0]  opv;
    logic [4:0]  dig;

    assign c = in_word.character;

    function automatic logic [31:0] mulb(input logic [31:0] a, input logic [1:0] rx);
        case (rx)
            RX_HEX:  return {a[27:0], 4'b0};
            RX_OCT:  return {a[28:0], 3'b0};
            RX_BIN:  return {a[30:0], 1'b0};
            default: return {a[28:0], 3'b0} + {a[30:0], 1'b0};
        endcase
    endfunction

    function automatic logic [4:0] base_of(input logic [1:0] rx);
        case (rx)
            RX_HEX:  return 5'd16;
            RX_OCT:  return 5'd8;
            RX_BIN:  return 5'd2;
            default: return 5'd10;
        endcase
    endfunction

    // literal status and value from a given literal state
    function automatic logic [34:0] lit_fin(input logic bad, input logic [7:0] len,
        input logic lz, input logic pre, input logic [1:0] rx, input logic [31:0] acc);
        if (bad || len == 8'd0) return {ST_BAD_DIGIT, 32'd0};
        if (lz && len == 8'd1) return {ST_OK, 32'd0};
        if (pre && len == 8'd2 && rx != RX_BIN) return {ST_BAD_DIGIT, 32'd0};
        return {ST_OK, acc};
    endfunction

    always_comb
    begin
        logic [31:0] lv;
        logic [2:0]  ls;
        logic        feed;
        logic        cnt;
        logic        put;
        logic [1:0]  rx;
        logic [3:0]  d;
        expr_next  = expr_reg;
        phase_next = phase_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        opc_next   = opc_reg;
        len_next   = len_reg;
        err_next   = err_reg;
        close_next = close_reg;
        lz_next    = lz_reg;
        pre_next   = pre_reg;
        bad_next   = bad_reg;
        long_next  = long_reg;
        rop_next   = rop_reg;
        rest_next  = rest_reg;
        opv        = op_of(c, is_op);
        dig        = digit_of(c);
        feed = 1'b0;
        cnt  = 1'b0;
        put  = 1'b0;
        rx   = radix_reg;
        d    = dig[3:0];
        {ls, lv} = lit_fin(bad_reg, len_reg, lz_reg, pre_reg, radix_reg, acc_reg);
        if (phase_reg == PH_FIRST)
        begin
            if (c == 8'h28)
            begin
                expr_next  = 1'b1;
                phase_next = PH_LEFT;
            end
            else
            begin
                expr_next  = 1'b0;
                phase_next = PH_LIT;
                feed       = 1'b1;
            end
        end
        else if (expr_reg)
        begin
            rest_next  = 1'b1;
            close_next = (c == 8'h29);
            if (phase_reg == PH_LEFT)
            begin
                if (is_op)
                begin
                    err_next   = ls;
                    left_next  = lv;
                    opc_next   = opv;
                    radix_next = RX_DEC;
                    acc_next   = '0;
                    len_next   = '0;
                    lz_next    = 1'b0;
                    pre_next   = 1'b0;
                    bad_next   = 1'b0;
                    phase_next = PH_RIGHT;
                end
                else if (c != 8'h20)
                    feed = 1'b1;
            end
            else if (phase_reg == PH_RIGHT)
            begin
                if (c == 8'h29)
                    phase_next = PH_DONE;
                else if (c != 8'h20)
                begin
                    if (is_op)
                    begin
                        rop_next = 1'b1;
                        cnt      = 1'b1;
                    end
                    else
                        feed = 1'b1;
                end
            end
        end
        else
            feed = 1'b1;

        if (feed)
        begin
            if (len_reg == 8'd0)
            begin
                if (c == 8'h30) lz_next = 1'b1;
                else put = 1'b1;
            end
            else if (len_reg == 8'd1 && lz_reg)
            begin
                if (c == 8'h78 || c == 8'h58)
                begin
                    radix_next = RX_HEX;
                    pre_next   = 1'b1;
                end
                else if (c == 8'h62 || c == 8'h42)
                begin
                    radix_next = RX_BIN;
                    pre_next   = 1'b1;
                end
                else if (c == 8'h64 || c == 8'h44)
                begin
                    radix_next = RX_DEC;
                    pre_next   = 1'b1;
                end
                else
                begin
                    radix_next = RX_OCT;
                    rx         = RX_OCT;
                    put        = 1'b1;
                end
            end
            else
                put = 1'b1;
            if (put)
            begin
                if (dig >= base_of(rx))
                    bad_next = 1'b1;
                else
                    acc_next = mulb(acc_reg, rx) + {28'd0, d};
            end
            cnt = 1'b1;
        end
        if (cnt && len_reg != 8'd255)
            len_next = len_reg + 8'd1;
        if (expr_reg && phase_reg != PH_FIRST && (phase_reg == PH_LEFT || phase_reg == PH_RIGHT)
            && (feed || cnt) && len_next >= 8'(OPERAND_MAX))
            long_next = 1'b1;
    end

    // finishing status from the state after the last character
    always_comb
    begin
        logic [31:0] rv;
        logic [2:0]  rs;
        {rs, rv} = lit_fin(bad_next, len_next, lz_next, pre_next, radix_next, acc_next);
        a_fin = left_next;
        b_fin = rv;
        st_fin = ST_OK;
        if (!expr_next)
        begin
            st_fin = rs;
            a_fin  = rv;
        end
        else if (!rest_next || !close_next) st_fin = ST_MALFORMED;
        else if (phase_next == PH_LEFT) st_fin = ST_NO_OP;
        else if (long_next) st_fin = ST_TOO_LONG;
        else if (len_next == 8'd0 || rop_next) st_fin = ST_MALFORMED;
        else if (err_next != ST_OK) st_fin = err_next;
        else if (rs != ST_OK) st_fin = rs;
        else if (opc_next == OP_DIV && rv == 32'd0) st_fin = ST_DIV_ZERO;
    end

    // upper partial product, only its low half reaches the result
    assign mhi = a_reg[15:0] * b_reg[31:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expr_reg  <= 1'b0;
            phase_reg <= PH_FIRST;
            radix_reg <= RX_DEC;
            acc_reg   <= '0;
            left_reg  <= '0;
            opc_reg   <= OP_ADD;
            len_reg   <= '0;
            err_reg   <= ST_OK;
            close_reg <= 1'b0;
            lz_reg    <= 1'b0;
            pre_reg   <= 1'b0;
            bad_reg   <= 1'b0;
            long_reg  <= 1'b0;
            rop_reg   <= 1'b0;
            rest_reg  <= 1'b0;
            mode_div_reg <= 1'b0;
            mode_mul_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (cmd.fin)
            begin
                // drop the parse state, keep operands for evaluation
                expr_reg  <= 1'b0;
                phase_reg <= PH_FIRST;
                radix_reg <= RX_DEC;
                acc_reg   <= '0;
                left_reg  <= '0;
                opc_reg   <= OP_ADD;
                len_reg   <= '0;
                err_reg   <= ST_OK;
                close_reg <= 1'b0;
                lz_reg    <= 1'b0;
                pre_reg   <= 1'b0;
                bad_reg   <= 1'b0;
                long_reg  <= 1'b0;
                rop_reg   <= 1'b0;
                rest_reg  <= 1'b0;
                mode_mul_reg <= expr_next && st_fin == ST_OK && opc_next == OP_MUL;
                mode_div_reg <= expr_next && st_fin == ST_OK && opc_next == OP_DIV;
            end
            else
            begin
                expr_reg  <= expr_next;
                phase_reg <= phase_next;
                radix_reg <= radix_next;
                acc_reg   <= acc_next;
                left_reg  <= left_next;
                opc_reg   <= opc_next;
                len_reg   <= len_next;
                err_reg   <= err_next;
                close_reg <= close_next;
                lz_reg    <= lz_next;
                pre_reg   <= pre_next;
                bad_reg   <= bad_next;
                long_reg  <= long_next;
                rop_reg   <= rop_next;
                rest_reg  <= rest_next;
            end
        end
    end

    // evaluation datapath
    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            a_reg  <= a_fin;
            b_reg  <= b_fin;
            st_reg <= st_fin;
            if (st_fin != ST_OK)
                res_reg <= '0;
            else if (!expr_next)
                res_reg <= a_fin;
            else
            begin
                case (opc_next)
                    OP_ADD:  res_reg <= a_fin + b_fin;
                    OP_SUB:  res_reg <= a_fin - b_fin;
                    OP_AND:  res_reg <= a_fin & b_fin;
                    OP_OR:   res_reg <= a_fin | b_fin;
                    default: res_reg <= '0;
                endcase
            end
        end
        if (cmd.mul_lo)
            mlo_reg <= 32'(a_reg * {16'd0, b_reg[15:0]});
        if (cmd.mul_hi)
            res_reg <= mlo_reg + {mhi[15:0], 16'd0};
        if (cmd.div_start)
        begin
            ma_reg   <= a_reg[31] ? 32'd0 - a_reg : a_reg;
            b_reg    <= b_reg[31] ? 32'd0 - b_reg : b_reg;
            neg_reg  <= a_reg[31] ^ b_reg[31];
            rem_reg  <= '0;
            quo_reg  <= '0;
            dcnt_reg <= 5'd31;
        end
        if (cmd.div_step)
        begin
            logic [32:0] r2;
            logic [31:0] q2;
            r2 = {rem_reg, ma_reg[dcnt_reg]};
            q2 = quo_reg;
            if (r2 >= {1'b0, b_reg})
            begin
                r2 = r2 - {1'b0, b_reg};
                q2[dcnt_reg] = 1'b1;
            end
            rem_reg  <= r2[31:0];
            quo_reg  <= q2;
            dcnt_reg <= dcnt_reg - 5'd1;
            if (dcnt_reg == 5'd0)
                res_reg <= neg_reg ? 32'd0 - q2 : q2;
        end
        if (cmd.res_load)
        begin
            out_word.value  <= res_reg;
            out_word.status <= st_reg;
        end
    end

    assign sts.need_mul = mode_mul_reg;
    assign sts.need_div = mode_div_reg;
    assign sts.div_done = (dcnt_reg == 5'd0);

`ifndef SYNTH
    a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> phase_reg == PH_FIRST && len_reg == 8'd0)
        else $error("parse state not cleared after last word");
    a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
        $past(len_reg) == 8'd255 |-> len_reg == 8'd255 || len_reg == 8'd0)
        else $error("operand length wrapped");
    a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mode_mul_reg && mode_div_reg))
        else $error("multiply and divide both selected");
`endif

endmodule

// File: rtl/radix_literal_expr_parser_core.sv
// Top level of the radix literal and two-operand expression parser.
// Each input word carries one character; the word with last set closes the
// argument and yields one result word (value, status) with status 0 ok,
// 1 bad digit, 2 malformed, 3 no operator, 4 divide by zero, 5 too long.
// Characters are taken one per cycle while the argument is parsed. After the
// last word the block evaluates through its EVAL and RES states for literals
// and + - & |; a multiply adds two partial product passes (32x16, then 16x16)
// and a divide a restoring divider that retires one quotient bit a cycle. The
// result sits in an output register, held until taken; the next argument is
// accepted once it has been loaded there.
module radix_literal_expr_parser_core
    import rlep_pkg::*;
#(
    parameter int OPERAND_MAX = 40
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  rlep_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output rlep_out_t out_data
);

    rlep_cmd_t cmd;
    rlep_sts_t sts;

    // sequence handshakes and arithmetic passes
    rlep_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_last   (in_data.last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // hold parse state and operands, evaluate
    rlep_dp #(.OPERAND_MAX(OPERAND_MAX)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_word (out_data)
    );

`ifndef SYNTH
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.last |=> !in_ready)
        else $error("input accepted during evaluation");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= ST_TOO_LONG)
        else $error("undefined status code");
`endif

endmodule

// File: bench/testbench.sv
// Self-checking bench for the radix literal and expression parser core.
module testbench;
    import rlep_pkg::*;

    localparam int OPERAND_LIMIT = 40;

    // Expected result words for the checker; holds the parse state of the predictor too.
    class parse_scoreboard;
        bit          in_expr;
        logic [2:0]  stage;
        logic [1:0]  radix;
        logic [31:0] acc;
        logic [31:0] left_val;
        logic [2:0]  op_code;
        int unsigned op_len;
        logic [2:0]  left_status;
        bit          close_seen;
        bit          zero_lead;
        bit          has_prefix;
        bit          bad_digit;
        bit          overlong;
        bit          op_in_right;
        bit          body_seen;
        rlep_out_t   pending[$];
        int          mismatches;
        int          checked;

        function void clear_literal();
            radix = RX_DEC;
            acc = '0;
            op_len = 0;
            zero_lead = 0;
            has_prefix = 0;
            bad_digit = 0;
        endfunction

        function void clear_all();
            in_expr = 0;
            stage = PH_FIRST;
            left_val = '0;
            op_code = OP_ADD;
            left_status = ST_OK;
            close_seen = 0;
            overlong = 0;
            op_in_right = 0;
            body_seen = 0;
            clear_literal();
        endfunction

        function int operator_index(logic [7:0] c);
            case (c)
                "+": return OP_ADD;
                "-": return OP_SUB;
                "&": return OP_AND;
                "|": return OP_OR;
                "*": return OP_MUL;
                "/": return OP_DIV;
                default: return -1;
            endcase
        endfunction

        function void bump_length();
            if (op_len < 255)
                op_len++;
        endfunction

        function void add_digit(logic [7:0] c);
            logic [31:0] d;
            logic [31:0] base;
            if (c >= "0" && c <= "9") d = c - "0";
            else if (c >= "a" && c <= "f") d = c - "a" + 10;
            else if (c >= "A" && c <= "F") d = c - "A" + 10;
            else d = 99;
            case (radix)
                RX_HEX: base = 16;
                RX_OCT: base = 8;
                RX_BIN: base = 2;
                default: base = 10;
            endcase
            if (d >= base)
                bad_digit = 1;
            else
                acc = acc * base + d;
        endfunction

        function void take_char(logic [7:0] c);
            if (op_len == 0)
            begin
                if (c == "0") zero_lead = 1;
                else add_digit(c);
            end
            else if (op_len == 1 && zero_lead)
            begin
                if (c == "x" || c == "X")
                begin
                    radix = RX_HEX;
                    has_prefix = 1;
                end
                else if (c == "b" || c == "B")
                begin
                    radix = RX_BIN;
                    has_prefix = 1;
                end
                else if (c == "d" || c == "D")
                begin
                    radix = RX_DEC;
                    has_prefix = 1;
                end
                else
                begin
                    radix = RX_OCT;
                    add_digit(c);
                end
            end
            else
                add_digit(c);
            bump_length();
        endfunction

        function logic [2:0] close_literal(output logic [31:0] v);
            v = '0;
            if (bad_digit || op_len == 0) return ST_BAD_DIGIT;
            if (zero_lead && op_len == 1) return ST_OK;
            if (has_prefix && op_len == 2 && radix != RX_BIN) return ST_BAD_DIGIT;
            v = acc;
            return ST_OK;
        endfunction

        function logic [2:0] apply_op(logic [31:0] a, logic [31:0] b, output logic [31:0] v);
            logic [31:0] ma;
            logic [31:0] mb;
            logic [31:0] q;
            v = '0;
            case (op_code)
                OP_ADD: v = a + b;
                OP_SUB: v = a - b;
                OP_AND: v = a & b;
                OP_OR:  v = a | b;
                OP_MUL: v = a * b;
                default:
                begin
                    if (b == 0) return ST_DIV_ZERO;
                    ma = a[31] ? -a : a;
                    mb = b[31] ? -b : b;
                    q = ma / mb;
                    v = (a[31] != b[31]) ? -q : q;
                end
            endcase
            return ST_OK;
        endfunction

        function logic [2:0] close_expr(output logic [31:0] v);
            logic [31:0] rv;
            logic [2:0]  rs;
            v = '0;
            if (!body_seen || !close_seen) return ST_MALFORMED;
            if (stage == PH_LEFT) return ST_NO_OP;
            if (overlong) return ST_TOO_LONG;
            if (op_len == 0 || op_in_right) return ST_MALFORMED;
            if (left_status != ST_OK) return left_status;
            rs = close_literal(rv);
            if (rs != ST_OK) return rs;
            return apply_op(left_val, rv, v);
        endfunction

        function void expr_step(logic [7:0] c);
            int op;
            op = operator_index(c);
            body_seen = 1;
            close_seen = (c == ")");
            if (stage == PH_LEFT)
            begin
                if (op >= 0)
                begin
                    left_status = close_literal(left_val);
                    op_code = op[2:0];
                    clear_literal();
                    stage = PH_RIGHT;
                end
                else if (c != " ")
                begin
                    take_char(c);
                    if (op_len >= OPERAND_LIMIT) overlong = 1;
                end
            end
            else if (stage == PH_RIGHT)
            begin
                if (c == ")")
                    stage = PH_DONE;
                else if (c != " ")
                begin
                    if (op >= 0)
                    begin
                        op_in_right = 1;
                        bump_length();
                    end
                    else
                        take_char(c);
                    if (op_len >= OPERAND_LIMIT) overlong = 1;
                end
            end
        endfunction

        // Note an accepted input word; queue a result when it closes the argument.
        function void note_input(rlep_in_t w);
            rlep_out_t r;
            logic [31:0] v;
            if (stage == PH_FIRST)
            begin
                if (w.character == "(")
                begin
                    in_expr = 1;
                    stage = PH_LEFT;
                end
                else
                begin
                    in_expr = 0;
                    stage = PH_LIT;
                    take_char(w.character);
                end
            end
            else if (in_expr)
                expr_step(w.character);
            else
                take_char(w.character);
            if (w.last)
            begin
                r.status = in_expr ? close_expr(v) : close_literal(v);
                r.value = (r.status == ST_OK) ? v : '0;
                pending.push_back(r);
                clear_all();
            end
        endfunction

        function void check_result(rlep_out_t got);
            rlep_out_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%0d status=%0d", got.value, got.status);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.value !== want.value || got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                             want.value, want.status, got.value, got.status);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    rlep_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    rlep_out_t out_data;

    parse_scoreboard sb;
    bit          quiet;      // no idling in the last part of the run
    bit          hold_off;   // long receiver stall requested
    int          words_sent;
    logic [7:0]  arg[$];

    radix_literal_expr_parser_core #(.OPERAND_MAX(OPERAND_LIMIT)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    // Predict from accepted words and check accepted results at each edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_input(in_data);
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Receiver: random stalls in bursts, one long hold-off when asked.
    initial
    begin
        int n;
        int k;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 0;
                for (k = 0; k < 200; k++)
                    @(posedge clk);
                hold_off = 0;
                out_ready <= 1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 12);
                out_ready <= 0;
                repeat (n) @(posedge clk);
                out_ready <= 1;
            end
            else
                out_ready <= 1;
        end
    end

    // Offer one word and hold it until accepted; sometimes idle a random burst first.
    task automatic send_word(logic [7:0] c, logic fin);
        rlep_in_t w;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        w.character = c;
        w.last = fin;
        in_valid <= 1;
        in_data <= w;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    // Send the queued argument, last flag on its final character.
    task automatic send_arg();
        int i;
        for (i = 0; i < arg.size(); i++)
            send_word(arg[i], i == arg.size() - 1);
        arg.delete();
    endtask

    task automatic push_str(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            arg.push_back(s[i]);
    endtask

    task automatic send_str(string s);
        push_str(s);
        send_arg();
    endtask

    // A random literal body, usually well formed, sometimes noisy.
    task automatic push_literal(int maxlen);
        int kind;
        int n;
        int i;
        string hexd;
        hexd = "0123456789abcdefABCDEF";
        kind = $urandom_range(0, 5);
        n = $urandom_range(1, maxlen);
        case (kind)
            0: push_str("0x");
            1: push_str("0b");
            2: push_str("0d");
            3: push_str("0");
            default: ;
        endcase
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 30) == 0)
                arg.push_back(8'($urandom_range(0, 255)));
            else case (kind)
                0: arg.push_back(hexd[$urandom_range(0, 21)]);
                1: arg.push_back(8'("0" + $urandom_range(0, 1)));
                3: arg.push_back(8'("0" + $urandom_range(0, 7)));
                default: arg.push_back(8'("0" + $urandom_range(0, 9)));
            endcase
        end
    endtask

    task automatic push_spaces();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) arg.push_back(" ");
    endtask

    task automatic random_arg();
        string ops;
        int sel;
        ops = "+-&|*/";
        sel = $urandom_range(0, 19);
        if (sel < 6)
        begin
            push_literal(sel == 0 ? 45 : 12);
        end
        else if (sel < 17)
        begin
            arg.push_back("(");
            push_spaces();
            push_literal(sel == 6 ? 42 : 10);
            push_spaces();
            arg.push_back(ops[$urandom_range(0, 5)]);
            push_spaces();
            if ($urandom_range(0, 9) == 0) push_str("0");
            else push_literal(sel == 7 ? 42 : 10);
            if ($urandom_range(0, 15) == 0) arg.push_back(ops[$urandom_range(0, 5)]);
            push_spaces();
            arg.push_back(")");
            if ($urandom_range(0, 10) == 0)
            begin
                push_str(" ab");
                arg.push_back($urandom_range(0, 1) ? ")" : "q");
            end
        end
        else
        begin
            // noise: random bytes, possibly opened as an expression
            if (sel == 17) arg.push_back("(");
            repeat ($urandom_range(1, 8)) arg.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int waited;
        sb = new();
        sb.clear_all();
        in_valid = 0;
        in_data = '0;
        quiet = 0;
        hold_off = 0;
        words_sent = 0;
        rst_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: radices, lone zero, empty digits, operators, error cases.
        send_str("0");
        send_str("4294967295");
        send_str("0xFFffFFff");
        send_str("0b");
        send_str("0x");
        send_str("017");
        send_str("1 2");
        send_str("(");
        send_str("(12+3");
        send_str("(12 3)");
        send_str("(7-9)");
        send_str("(0xf0 & 0b1111 )");
        send_str("(0d5|010)");
        send_str("(65536*65537)");
        send_str("(0x80000000/0xffffffff)");
        send_str("(7/0)");
        send_str("(-7/2)");
        send_str("(1+)");
        send_str("(1+2+3)");
        send_str("(1+2) x)");
        send_str("(1234567890123456789012345678901234567890+1)");
        send_str("(08+1)");
        send_str("(1+0x)");
        send_word(8'hFF, 1);

        // Random arguments; a long receiver hold-off early to fill the block.
        while (words_sent < 1300)
        begin
            if (words_sent > 200 && words_sent < 260)
                hold_off = 1;
            if (words_sent > 1100)
                quiet = 1;
            random_arg();
            send_arg();
        end
        in_valid <= 0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (50) @(posedge clk);
        $display("Sent %0d character words; checked %0d results over literals and expressions.",
                 words_sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #20000000;
        $display("timeout");
        $display("Verification failed");
        $finish;
    end
endmodule

// File: filelist.f
rtl/rlep_pkg.sv
rtl/rlep_ctrl.sv
rtl/rlep_dp.sv
rtl/radix_literal_expr_parser_core.sv
bench/testbench.sv
